/* hdl/blr_pkg.sv */
// Constants and shared types for the bounded LCG random generator.
// No dependencies; imported by blr_rem, bounded_lcg_random, blr_chk, blr_checker and the bench top.
`default_nettype none
package blr_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned DRAW_SH = 16;
    localparam int unsigned DRAW_W  = DATA_W - DRAW_SH;
    localparam int unsigned DIGIT_W = 8;
    localparam int unsigned MUL_STEPS = DATA_W / DIGIT_W;

    localparam logic [DATA_W-1:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [DATA_W-1:0] LCG_ADD = 64'd1442695040888963407;

    // control from the sequencer to the remainder unit
    typedef struct packed {
        logic start;
        logic bypass;   // span wrapped to zero: pass the draw through
    } blr_div_ctrl_t;

endpackage
`default_nettype wire

/* hdl/blr_rem.sv */
// Bit-serial restoring remainder unit: draw mod span, one draw bit per cycle.
// Depends on blr_pkg.
`default_nettype none
module blr_rem
    import blr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire blr_div_ctrl_t       ctrl,
    input  wire logic [DRAW_W-1:0]   dividend,
    input  wire logic [DATA_W-1:0]   divisor,
    output logic                     done,
    output logic [DRAW_W-1:0]        remainder
);

    localparam int unsigned CNT_W = $clog2(DRAW_W + 1);

    logic [DRAW_W-1:0] dvd_reg, dvd_next;
    logic [DRAW_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              bypass_reg, bypass_next;
    logic              done_reg, done_next;
    logic [DRAW_W:0]   shifted;
    logic [DATA_W-1:0] shifted_ext;

    assign shifted     = {rem_reg, dvd_reg[DRAW_W-1]};
    assign shifted_ext = {{(DATA_W-DRAW_W-1){1'b0}}, shifted};

    always_comb begin
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        bypass_next = bypass_reg;
        done_next   = 1'b0;
        if (ctrl.start) begin
            dvd_next    = dividend;
            rem_next    = '0;
            cnt_next    = CNT_W'(DRAW_W);
            busy_next   = 1'b1;
            bypass_next = ctrl.bypass;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DRAW_W-2:0], 1'b0};
            // partial remainder never exceeds the draw prefix, so it fits DRAW_W
            if (!bypass_reg && shifted_ext >= divisor) begin
                rem_next = DRAW_W'(shifted_ext - divisor);
            end else begin
                rem_next = shifted[DRAW_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        bypass_reg <= bypass_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

/* hdl/bounded_lcg_random.sv */
// Bounded random generator: one 64-bit LCG step per request, reduced into [lo, hi].
// Top level; depends on blr_pkg and blr_rem.
//
// Usage:
//   s_ channel: one word carries bound_low (bits 63:0) and bound_high (127:64),
//   signed; reversed bounds are swapped. m_ channel: one word with random_value.
//   cfg_wr_en/cfg_wr_data load the generator state (zero loads as 1); write
//   only while no request is in flight.
// Sequence:
//   A request passes from acceptance through the state multiply (one 8-bit
//   digit of the state per cycle), the increment, the remainder (one draw
//   bit per cycle in blr_rem), ST_DIV and ST_OUT into the result register.
//   s_tready is high only while idle, so the next request word is taken only
//   after the previous result has been written to the output register.
// Reset (aresetn low, synchronous): generator state becomes 1, no result pending.
// Stall: a finished result waits in the output register while m_tready is low;
//   the next request is still accepted, but its result waits until the
//   register is taken.
`default_nettype none
module bounded_lcg_random
    import blr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [DATA_W-1:0]   cfg_wr_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [2*DATA_W-1:0] s_tdata,   // bound_low, bound_high
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [DATA_W-1:0]        m_tdata    // random_value
);

    localparam int unsigned STEP_W = $clog2(MUL_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [DATA_W-1:0]   gen_reg;
    logic [DATA_W-1:0]   lo_reg;
    logic [DATA_W-1:0]   hi_reg;
    logic [DATA_W-1:0]   span_reg;
    logic [DATA_W-1:0]   mcand_reg;
    logic [DATA_W-1:0]   mplier_reg;
    logic [DATA_W-1:0]   acc_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;

    logic [DATA_W-1:0]   in_lo, in_hi;
    logic                swap;
    logic [DATA_W-1:0]   partial;
    logic [DATA_W-1:0]   gen_next;
    blr_div_ctrl_t       div_ctrl;
    logic                div_done;
    logic [DRAW_W-1:0]   div_rem;

    assign in_lo = s_tdata[DATA_W-1:0];
    assign in_hi = s_tdata[2*DATA_W-1:DATA_W];
    assign swap  = $signed(in_lo) > $signed(in_hi);

    // one digit of the state times the shifted multiplier constant, mod 2^64
    assign partial  = DATA_W'(mcand_reg * mplier_reg[DIGIT_W-1:0]);
    assign gen_next = acc_reg + LCG_ADD;

    assign div_ctrl.start  = (state_reg == ST_ADD);
    assign div_ctrl.bypass = (span_reg == '0);

    blr_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (gen_next[DATA_W-1:DRAW_SH]),
        .divisor   (span_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gen_reg      <= DATA_W'(1);
            m_tvalid_reg <= 1'b0;
            step_reg     <= '0;
        end else begin
            // ST_OUT refills the output register itself when the word is taken
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                gen_reg <= (cfg_wr_data == '0) ? DATA_W'(1) : cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        lo_reg     <= swap ? in_hi : in_lo;
                        hi_reg     <= swap ? in_lo : in_hi;
                        mcand_reg  <= LCG_MUL;
                        mplier_reg <= gen_reg;
                        acc_reg    <= '0;
                        step_reg   <= '0;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    span_reg   <= hi_reg - lo_reg + DATA_W'(1);
                    acc_reg    <= acc_reg + partial;
                    mcand_reg  <= {mcand_reg[DATA_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    mplier_reg <= {{DIGIT_W{1'b0}}, mplier_reg[DATA_W-1:DIGIT_W]};
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    gen_reg   <= gen_next;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= lo_reg + {{DRAW_SH{1'b0}}, div_rem};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

/* hdl/blr_chk.sv */
// Port-level checker for bounded_lcg_random, attached by the bind below.
// Depends on blr_pkg for widths.
`default_nettype none
module blr_chk
    import blr_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [DATA_W-1:0]   m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one request at a time: the multiply keeps the input closed for a while
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("request accepted while another is in flight");

    // no result can appear right after a request is taken
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too early");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind bounded_lcg_random blr_chk u_blr_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

/* bench/blr_checker.sv */
// Scoreboard for bounded_lcg_random: keeps its own copy of the generator state,
// predicts each random_value when a request word is taken and compares results in order.
// Depends on blr_pkg for widths and the LCG constants.
`timescale 1ns / 1ps
module blr_checker
    import blr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [DATA_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [2*DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [DATA_W-1:0]   m_tdata,
    output int                  fail_count,
    output int                  expected_left,
    output int                  results_checked
);

    logic [DATA_W-1:0] lcg_state;
    logic [DATA_W-1:0] expected_values[$];
    int                errors;
    int                checked;

    function automatic logic [DATA_W-1:0] lcg_next(input logic [DATA_W-1:0] cur);
        return cur * LCG_MUL + LCG_ADD;
    endfunction

    function automatic logic [DATA_W-1:0] range_value(input logic [DATA_W-1:0] first,
                                                      input logic [DATA_W-1:0] second,
                                                      input logic [DATA_W-1:0] gen);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] draw;
        logic [DATA_W-1:0] offset;
        lo = first;
        hi = second;
        if ($signed(first) > $signed(second)) begin
            lo = second;
            hi = first;
        end
        span = hi - lo + 64'd1;
        draw = gen >> DRAW_SH;
        // full signed range wraps the span to zero: draw goes through unreduced
        offset = (span == '0) ? draw : draw % span;
        return lo + offset;
    endfunction

    initial begin
        errors = 0;
        checked = 0;
        lcg_state = 64'd1;
        fail_count = 0;
        expected_left = 0;
        results_checked = 0;
    end

    always @(posedge aclk) begin
        logic [DATA_W-1:0] want;
        if (!aresetn) begin
            lcg_state = 64'd1;
            expected_values.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    errors++;
                    $display("%0t: random_value %0d with no request outstanding",
                             $time, $signed(m_tdata));
                end else begin
                    want = expected_values.pop_front();
                    checked++;
                    if (m_tdata !== want) begin
                        errors++;
                        $display("%0t: random_value mismatch, expected %0d got %0d",
                                 $time, $signed(want), $signed(m_tdata));
                    end
                end
            end
            if (cfg_wr_en)
                lcg_state = (cfg_wr_data == '0) ? 64'd1 : cfg_wr_data;
            if (s_tvalid && s_tready) begin
                lcg_state = lcg_next(lcg_state);
                expected_values.push_back(range_value(s_tdata[DATA_W-1:0],
                                                      s_tdata[2*DATA_W-1:DATA_W],
                                                      lcg_state));
            end
        end
        fail_count      <= errors;
        expected_left   <= expected_values.size();
        results_checked <= checked;
    end

endmodule

/* bench/tb_bounded_lcg_random.sv */
// Top of the bounded_lcg_random bench: clock, reset, seed writes and request stimulus.
// Instantiates the block and blr_checker; depends on blr_pkg.
`timescale 1ns / 1ps
module tb_bounded_lcg_random;
    import blr_pkg::*;

    localparam logic [DATA_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] SPAN48  = 64'h0001_0000_0000_0000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 340;
    localparam int PHASES         = 5;

    typedef struct packed {
        logic [DATA_W-1:0] bound_high;
        logic [DATA_W-1:0] bound_low;
    } request_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [DATA_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*DATA_W-1:0] s_tdata = '0;   // bound_low, bound_high
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;        // random_value

    int  fail_count;
    int  expected_left;
    int  results_checked;
    int  words_sent = 0;
    int  seed_writes = 0;
    int  idle_cycles = 0;
    int  ready_hold = 0;
    bit  source_gaps = 1'b1;
    bit  sink_stalls = 1'b1;

    bounded_lcg_random i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    blr_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length(input bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [DATA_W-1:0] pick_edge_value();
        case ($urandom_range(0, 4))
            0: return S64_MIN;
            1: return S64_MAX;
            2: return '0;
            3: return '1;
            default: return rand64();
        endcase
    endfunction

    function automatic request_t random_request();
        request_t          req;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        lo = rand64();
        case ($urandom_range(0, 9))
            0, 1, 2: hi = lo + $urandom_range(0, 1000);
            3, 4:    hi = lo + (rand64() >> $urandom_range(0, 63));
            5, 6:    hi = rand64();
            7:       hi = lo + SPAN48 - 64'd3 + $urandom_range(0, 5);
            8: begin
                lo = pick_edge_value();
                hi = pick_edge_value();
            end
            default: begin
                lo = 64'($signed($urandom_range(0, 100)) - 50);
                hi = 64'($signed($urandom_range(0, 100)) - 50);
            end
        endcase
        if ($urandom_range(0, 1)) begin
            req.bound_low  = hi;
            req.bound_high = lo;
        end else begin
            req.bound_low  = lo;
            req.bound_high = hi;
        end
        return req;
    endfunction

    // valid is dropped only when a gap follows, so it never falls and rises in one step
    task automatic send_request(input request_t req);
        int gap;
        gap = gap_length(source_gaps);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= rand64();
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_bounds(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        request_t req;
        req.bound_low  = lo;
        req.bound_high = hi;
        send_request(req);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
    endtask

    task automatic load_seed(input logic [DATA_W-1:0] seed);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        seed_writes++;
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!sink_stalls || $urandom_range(0, 1)) begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 30);
        end else begin
            m_tready   <= 1'b0;
            ready_hold <= gap_length(1'b1);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [DATA_W-1:0] phase_seed;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words on the reset state of the generator
        send_bounds('0, '0);
        send_bounds(S64_MIN, S64_MAX);          // full range, span wraps
        send_bounds(S64_MAX, S64_MIN);          // full range given reversed
        send_bounds(S64_MIN, S64_MIN);
        send_bounds(S64_MAX, S64_MAX);
        send_bounds(64'd5, -64'sd5);            // reversed
        send_bounds(-64'sd10, 64'd10);
        send_bounds('0, SPAN48 - 64'd1);        // span exactly 2^48
        send_bounds('0, SPAN48);                // wide span
        send_bounds('0, SPAN48 - 64'd2);
        send_bounds(S64_MIN, '1);
        send_bounds('0, S64_MAX);
        send_bounds('1, '0);
        send_bounds(S64_MIN + 64'd1, S64_MAX);
        send_bounds(S64_MIN, S64_MAX - 64'd1);
        send_bounds(S64_MAX, S64_MAX - 64'd1);
        send_bounds(64'd1, 64'd7);
        send_bounds(64'd100, 64'd3);
        send_bounds(rand64(), rand64());
        send_bounds(S64_MAX, '1);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: phase_seed = '0;             // zero seed loads as one
                1: phase_seed = '1;
                2: phase_seed = rand64();
                3: phase_seed = S64_MIN;
                default: phase_seed = 64'd1;
            endcase
            load_seed(phase_seed);
            source_gaps = (phase != 1) && (phase != 3);
            sink_stalls = (phase != 1) && (phase != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
        end

        wait_drained();
        repeat (70) @(posedge aclk);
        $display("covered %0d request words (directed and random) under %0d seed loads",
                 words_sent, seed_writes);
        $display("%0d random values compared, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && expected_left == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* bounded_lcg_random.f */
hdl/blr_pkg.sv
hdl/blr_rem.sv
hdl/bounded_lcg_random.sv
hdl/blr_chk.sv
bench/blr_checker.sv
bench/tb_bounded_lcg_random.sv
